// ----- hw/rtl/prs_pkg.sv -----
// Package for the packet response sequencer.
// Holds item, result and state types, flag bit positions and status codes.
// Used by every module under hw/rtl; depends on nothing.
package prs_pkg;

	localparam int MaxPayloadReset   = 52;
	localparam int StdinChannelReset = 0;

	// Header flag bit positions.
	localparam int FlagNak    = 1;
	localparam int FlagRtx    = 2;
	localparam int FlagAckReq = 3;
	localparam int FlagFrag   = 4;
	localparam int FlagEvent  = 5;

	// Status words carried in a NAK payload.
	localparam logic [15:0] StChecksum = 16'h0005;
	localparam logic [15:0] StSequence = 16'h0006;
	localparam logic [15:0] StTimeout  = 16'h0003;
	localparam logic [15:0] StBusy     = 16'h0004;

	// Event codes for the system channel and the stdin channel.
	localparam logic [15:0] EvtChanAdd  = 16'h0000;
	localparam logic [15:0] EvtChanDel  = 16'h0001;
	localparam logic [15:0] EvtReboot   = 16'h0002;
	localparam logic [15:0] EvtRunning  = 16'h0001;
	localparam logic [15:0] EvtNone     = 16'hFFFF;
	localparam logic [15:0] LenMax      = 16'hFFFF;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_MAX_PAYLOAD   = 1'b0,
		CFG_STDIN_CHANNEL = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		DISP_DROPPED   = 3'd0,
		DISP_STALE     = 3'd1,
		DISP_EVENT     = 3'd2,
		DISP_FRAGMENT  = 3'd3,
		DISP_COMPLETE  = 3'd4,
		DISP_NAK       = 3'd5,
		DISP_RESTARTED = 3'd6
	} disp_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_CHECKSUM = 3'd1,
		ERR_SEQUENCE = 3'd2,
		ERR_TIMEOUT  = 3'd3,
		ERR_BUSY     = 3'd4,
		ERR_OTHER    = 3'd5
	} err_t;

	typedef struct packed {
		logic        restart;
		logic [7:0]  packet_sequence;
		logic [7:0]  packet_channel;
		logic [5:0]  packet_flags;
		logic [7:0]  packet_opcode;
		logic [15:0] payload_length;
		logic        crc_ok;
		logic [15:0] first_word;
	} item_t;

	typedef struct packed {
		disp_t       disposition;
		logic        send_ack;
		logic [7:0]  ack_sequence;
		logic [7:0]  ack_channel;
		logic [7:0]  ack_opcode;
		err_t        error_code;
		logic [15:0] response_length;
		logic        resync_needed;
		logic        channels_changed;
		logic        script_active;
		logic [7:0]  expected_sequence;
	} result_t;

	typedef struct packed {
		logic [7:0]  next_sequence;
		logic        reboot_flag;
		logic        stale_channels_flag;
		logic        running_flag;
		logic [15:0] assembled_bytes;
		logic [15:0] leading_word;
	} seq_state_t;

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? LenMax : s[15:0];
	endfunction

endpackage

// ----- hw/rtl/prs_decide.sv -----
// Combinational decision logic for one packet header.
// Produces the result item and the next sequencer state; uses prs_pkg.
module prs_decide
	import prs_pkg::*;
(
	input  item_t       item,
	input  seq_state_t  cur,
	input  logic [15:0] max_payload,
	input  logic [7:0]  stdin_channel,
	output result_t     res,
	output seq_state_t  nxt
);

	logic        seq_match;
	logic        seq_ok;
	logic [15:0] merged;
	logic [15:0] total;
	logic [15:0] evt_code;
	logic [15:0] status;

	assign seq_match = (item.packet_sequence == cur.next_sequence);
	assign seq_ok    = item.packet_flags[FlagEvent] | item.packet_flags[FlagRtx] |
	                   seq_match | (item.packet_opcode == 8'd0);
	assign total     = sat_add16(cur.assembled_bytes, item.payload_length);
	assign evt_code  = (item.payload_length >= 16'd2) ? item.first_word : EvtNone;
	assign status    = (total >= 16'd2) ? merged : 16'd0;

	// Leading word of the stream once this payload is appended; a single
	// buffered byte takes the new payload's first byte as its upper half.
	always_comb begin
		if (cur.assembled_bytes == 16'd0) begin
			merged = item.first_word;
		end else if (cur.assembled_bytes == 16'd1) begin
			merged = {item.first_word[7:0], cur.leading_word[7:0]};
		end else begin
			merged = cur.leading_word;
		end
	end

	always_comb begin
		result_t r;
		r   = '0;
		nxt = cur;
		if (item.restart) begin
			nxt           = '0;
			r.disposition = DISP_RESTARTED;
		end else if (!item.crc_ok || (item.payload_length > max_payload) || !seq_ok) begin
			r.disposition = DISP_DROPPED;
		end else if (item.packet_flags[FlagRtx] && !seq_match) begin
			r.disposition = DISP_STALE;
			if (item.packet_flags[FlagAckReq]) begin
				r.send_ack     = 1'b1;
				r.ack_sequence = item.packet_sequence;
				r.ack_channel  = item.packet_channel;
				r.ack_opcode   = item.packet_opcode;
			end
		end else begin
			if (item.packet_flags[FlagAckReq]) begin
				r.send_ack     = 1'b1;
				r.ack_sequence = cur.next_sequence;
				r.ack_channel  = item.packet_channel;
				r.ack_opcode   = item.packet_opcode;
			end
			if (item.packet_flags[FlagEvent]) begin
				r.disposition = DISP_EVENT;
				if (item.packet_channel == 8'd0) begin
					if (evt_code == EvtReboot) begin
						nxt.reboot_flag   = 1'b1;
						nxt.next_sequence = 8'd0;
					end else if (evt_code == EvtChanAdd || evt_code == EvtChanDel) begin
						nxt.stale_channels_flag = 1'b1;
					end
				end else if (item.packet_channel == stdin_channel) begin
					nxt.running_flag = (evt_code == EvtRunning);
				end
			end else begin
				nxt.next_sequence = cur.next_sequence + 8'd1;
				if (item.packet_flags[FlagFrag]) begin
					r.disposition = DISP_FRAGMENT;
					if (item.payload_length != 16'd0) begin
						nxt.leading_word    = merged;
						nxt.assembled_bytes = total;
					end
				end else begin
					r.response_length   = total;
					nxt.assembled_bytes = 16'd0;
					nxt.leading_word    = 16'd0;
					if (item.packet_flags[FlagNak]) begin
						r.disposition = DISP_NAK;
						priority if (status == StChecksum) r.error_code = ERR_CHECKSUM;
						else if (status == StSequence)     r.error_code = ERR_SEQUENCE;
						else if (status == StTimeout)      r.error_code = ERR_TIMEOUT;
						else if (status == StBusy)         r.error_code = ERR_BUSY;
						else                               r.error_code = ERR_OTHER;
					end else begin
						r.disposition = DISP_COMPLETE;
					end
				end
			end
		end
		r.resync_needed     = nxt.reboot_flag;
		r.channels_changed  = nxt.stale_channels_flag;
		r.script_active     = nxt.running_flag;
		r.expected_sequence = nxt.next_sequence;
		res = r;
	end

endmodule

// ----- hw/rtl/prs_state.sv -----
// Sequencer state register: expected sequence, event flags and fragment sums.
// Loads the next state from prs_decide when an item completes; uses prs_pkg.
module prs_state
	import prs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  seq_state_t nxt,
	output seq_state_t cur
);

	seq_state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (load) begin
			state_q <= nxt;
		end
	end

	assign cur = state_q;

endmodule

// ----- hw/rtl/packet_response_sequencer_top.sv -----
// Packet response sequencer, top level: stream ports, input register, result register.
// Depends on prs_pkg, prs_decide and prs_state.
// An accepted header passes from the input register to the result register, raising m_tvalid.
// Throughput: one header per cycle unless the result stalls; the state read by the
// decision logic is written back as the result register loads, so headers follow back to back.
// Reset clears the sequencer state and both valid flags, and loads the configuration reset values.
module packet_response_sequencer_top
	import prs_pkg::*;
#(
	parameter logic [15:0] MAX_PAYLOAD_RESET   = 16'(MaxPayloadReset),
	parameter logic [7:0]  STDIN_CHANNEL_RESET = 8'(StdinChannelReset)
)(
	input  logic        clk,
	input  logic        arst_n,
	// Header stream in.
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] restart
	input  logic [0:0]  s_tuser,
	// [7:0] packet_sequence, [15:8] packet_channel, [21:16] packet_flags,
	// [29:22] packet_opcode, [45:30] payload_length, [46] crc_ok,
	// [62:47] first_word, [63] zero
	input  logic [63:0] s_tdata,
	// Result stream out.
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] disposition
	output logic [2:0]  m_tuser,
	// [0] send_ack, [8:1] ack_sequence, [16:9] ack_channel, [24:17] ack_opcode,
	// [27:25] error_code, [43:28] response_length, [44] resync_needed,
	// [45] channels_changed, [46] script_active, [54:47] expected_sequence, [55] zero
	output logic [55:0] m_tdata,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic        max_payload_q_unused;
	logic [15:0] max_payload_q;
	logic [7:0]  stdin_channel_q;

	item_t       item_s1;
	logic        valid_s1;
	result_t     res_s2;
	logic        valid_s2;

	result_t     res;
	seq_state_t  cur;
	seq_state_t  nxt;
	logic        advance;

	// Configuration writes are taken at once; the user must send them only while idle, as the block does not enforce it.
	assign cfg_ready = 1'b1;
	assign max_payload_q_unused = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q   <= MAX_PAYLOAD_RESET;
			stdin_channel_q <= STDIN_CHANNEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_PAYLOAD:   max_payload_q   <= cfg_data;
				CFG_STDIN_CHANNEL: stdin_channel_q <= cfg_data[7:0];
				default:           max_payload_q   <= max_payload_q;
			endcase
		end
	end

	// The held header moves on whenever the result register is empty or being drained.
	// The input register refills in the same cycle, so while the result is stalled the slave
	// side takes only the one header that fits in the input register and then blocks.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.restart         <= s_tuser[0];
			item_s1.packet_sequence <= s_tdata[7:0];
			item_s1.packet_channel  <= s_tdata[15:8];
			item_s1.packet_flags    <= s_tdata[21:16];
			item_s1.packet_opcode   <= s_tdata[29:22];
			item_s1.payload_length  <= s_tdata[45:30];
			item_s1.crc_ok          <= s_tdata[46];
			item_s1.first_word      <= s_tdata[62:47];
		end
	end

	prs_decide u_decide (
		.item          (item_s1),
		.cur           (cur),
		.max_payload   (max_payload_q),
		.stdin_channel (stdin_channel_q),
		.res           (res),
		.nxt           (nxt)
	);

	// State commits together with the result register load.
	prs_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.nxt    (nxt),
		.cur    (cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.disposition;
	assign m_tdata  = {max_payload_q_unused,
	                   res_s2.expected_sequence,
	                   res_s2.script_active,
	                   res_s2.channels_changed,
	                   res_s2.resync_needed,
	                   res_s2.response_length,
	                   res_s2.error_code,
	                   res_s2.ack_opcode,
	                   res_s2.ack_channel,
	                   res_s2.ack_sequence,
	                   res_s2.send_ack};

	// An error code appears only on a NAK result.
	a_err_only_nak: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.disposition != DISP_NAK) |-> res_s2.error_code == ERR_NONE)
		else $error("error code on a result that is not a NAK");

	// A restart result reports a fully cleared sequencer.
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.disposition == DISP_RESTARTED) |->
		(res_s2.expected_sequence == 8'd0 && !res_s2.resync_needed &&
		 !res_s2.channels_changed && !res_s2.script_active))
		else $error("restart result with state left set");

	// A stalled result holds the decided item and the sequencer state.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(res_s2) && $stable(cur)))
		else $error("result or state changed during a stall");

	// Acknowledge fields are zero unless an acknowledge is requested.
	a_ack_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res_s2.send_ack) |->
		(res_s2.ack_sequence == 8'd0 && res_s2.ack_channel == 8'd0 &&
		 res_s2.ack_opcode == 8'd0))
		else $error("acknowledge fields set without send_ack");

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for packet_response_sequencer_top: directed header cases, then
// randomized well-formed traffic and noise under several register settings.
// Depends on prs_pkg and the RTL under hw/rtl; needs no files or arguments.
module tb;
	import prs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Header flag masks; all but F_ACK (bit 0) come from the bit positions in the package.
	localparam logic [5:0] F_ACK    = 6'd1;
	localparam logic [5:0] F_NAK    = 6'(1 << FlagNak);
	localparam logic [5:0] F_RTX    = 6'(1 << FlagRtx);
	localparam logic [5:0] F_ACKREQ = 6'(1 << FlagAckReq);
	localparam logic [5:0] F_FRAG   = 6'(1 << FlagFrag);
	localparam logic [5:0] F_EVENT  = 6'(1 << FlagEvent);

	// Cycles with no accepted request on any channel before the run is abandoned.
	// The longest legal quiet spell is a long sender gap plus a long
	// receiver stall plus the pipeline.
	localparam int STUCK_LIMIT = 2000;
	// A request passes through the input register and then the result register
	// before its result can be taken.
	localparam int PIPE_DEPTH = 2;
	// Non-dropped headers wanted from each random phase.
	localparam int PHASE_GOAL = 295;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [0:0]  s_tuser   = 1'b0;
	logic [63:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [2:0]  m_tuser;
	logic [55:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = CFG_MAX_PAYLOAD;
	logic [15:0] cfg_data  = '0;

	packet_response_sequencer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Shadow of the sequencer: its registers and its running state, kept in step
	// with every accepted request.
	logic [15:0] cfg_max_payload = 16'(MaxPayloadReset);
	logic [7:0]  cfg_stdin_chan  = 8'(StdinChannelReset);
	logic [7:0]  seq_expected    = '0;
	logic        reboot_seen     = 1'b0;
	logic        chan_changed    = 1'b0;
	logic        script_running  = 1'b0;
	logic [15:0] asm_total       = '0;
	logic [15:0] lead_word       = '0;
	logic        asm_open        = 1'b0;

	// Predicted results, oldest first, waiting for the result stream.
	result_t expected_q[$];

	int mismatches     = 0;
	int results_seen   = 0;
	int headers_sent   = 0;
	int headers_taken  = 0;
	int settings_used  = 1;
	int disp_seen[8];
	int stuck_cycles   = 0;
	int tx_quiet       = 0;
	int rx_quiet       = 0;
	int rx_stall       = 0;

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(24, 64);
	endfunction

	// Sender gap, with occasional back-to-back stretches.
	function automatic int tx_gap();
		if (tx_quiet > 0) begin
			tx_quiet--;
			return 0;
		end
		if ($urandom_range(0, 99) < 3) tx_quiet = $urandom_range(30, 120);
		return idle_length();
	endfunction

	function automatic logic [15:0] add_capped(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = 17'(a) + 17'(b);
		return (s > 17'(LenMax)) ? LenMax : s[15:0];
	endfunction

	// First two bytes of the assembled stream once this payload is appended.
	// With exactly one byte held, the new payload's first byte fills the upper half.
	function automatic logic [15:0] stream_head(input logic [15:0] fw);
		if (asm_total == 16'd0) return fw;
		if (asm_total == 16'd1) return {fw[7:0], lead_word[7:0]};
		return lead_word;
	endfunction

	function automatic void clear_assembly();
		asm_total = '0;
		lead_word = '0;
		asm_open  = 1'b0;
	endfunction

	// Works out the response to one header and advances the shadow state.
	function automatic result_t predict_response(input item_t h);
		result_t     r;
		logic        in_order;
		logic [15:0] event_code;
		logic [15:0] word;
		logic [15:0] total;
		logic [15:0] status;
		r = '0;
		r.disposition = DISP_DROPPED;
		r.error_code  = ERR_NONE;
		if (h.restart) begin
			seq_expected   = '0;
			reboot_seen    = 1'b0;
			chan_changed   = 1'b0;
			script_running = 1'b0;
			clear_assembly();
			r.disposition = DISP_RESTARTED;
		end else begin
			// Events, retransmits and protocol sync bypass the sequence check.
			in_order = h.packet_flags[FlagEvent] || h.packet_flags[FlagRtx] ||
				h.packet_sequence == seq_expected || h.packet_opcode == 8'd0;
			if (!h.crc_ok || h.payload_length > cfg_max_payload || !in_order) begin
				r.disposition = DISP_DROPPED;
			end else if (h.packet_flags[FlagRtx] && h.packet_sequence != seq_expected) begin
				r.disposition = DISP_STALE;
				if (h.packet_flags[FlagAckReq]) begin
					r.send_ack     = 1'b1;
					r.ack_sequence = h.packet_sequence;
					r.ack_channel  = h.packet_channel;
					r.ack_opcode   = h.packet_opcode;
				end
			end else begin
				if (h.packet_flags[FlagAckReq]) begin
					r.send_ack     = 1'b1;
					r.ack_sequence = seq_expected;
					r.ack_channel  = h.packet_channel;
					r.ack_opcode   = h.packet_opcode;
				end
				if (h.packet_flags[FlagEvent]) begin
					event_code = (h.payload_length >= 16'd2) ? h.first_word : EvtNone;
					r.disposition = DISP_EVENT;
					if (h.packet_channel == 8'd0) begin
						if (event_code == EvtReboot) begin
							reboot_seen  = 1'b1;
							seq_expected = '0;
						end else if (event_code == EvtChanAdd || event_code == EvtChanDel) begin
							chan_changed = 1'b1;
						end
					end else if (h.packet_channel == cfg_stdin_chan) begin
						script_running = (event_code == EvtRunning);
					end
				end else begin
					seq_expected = seq_expected + 8'd1;
					word  = stream_head(h.first_word);
					total = add_capped(asm_total, h.payload_length);
					if (h.packet_flags[FlagFrag]) begin
						r.disposition = DISP_FRAGMENT;
						if (h.payload_length != 16'd0) begin
							lead_word = word;
							asm_total = total;
						end
						asm_open = 1'b1;
					end else begin
						r.response_length = total;
						if (h.packet_flags[FlagNak]) begin
							status = (total >= 16'd2) ? word : 16'd0;
							r.disposition = DISP_NAK;
							case (status)
								StChecksum: r.error_code = ERR_CHECKSUM;
								StSequence: r.error_code = ERR_SEQUENCE;
								StTimeout:  r.error_code = ERR_TIMEOUT;
								StBusy:     r.error_code = ERR_BUSY;
								default:    r.error_code = ERR_OTHER;
							endcase
						end else begin
							r.disposition = DISP_COMPLETE;
						end
						clear_assembly();
					end
				end
			end
		end
		r.resync_needed     = reboot_seen;
		r.channels_changed  = chan_changed;
		r.script_active     = script_running;
		r.expected_sequence = seq_expected;
		return r;
	endfunction

	function automatic item_t make_header(input logic [7:0] seq, input logic [7:0] chan,
			input logic [5:0] flags, input logic [7:0] opc, input logic [15:0] len,
			input logic crc, input logic [15:0] fw);
		item_t h;
		h = '0;
		h.packet_sequence = seq;
		h.packet_channel  = chan;
		h.packet_flags    = flags;
		h.packet_opcode   = opc;
		h.payload_length  = len;
		h.crc_ok          = crc;
		h.first_word      = fw;
		return h;
	endfunction

	function automatic logic [15:0] pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20) return 16'($urandom_range(0, 2));
		if (r < 26 && cfg_max_payload != LenMax)
			return 16'($urandom_range(int'(cfg_max_payload) + 1, 65535));
		return 16'($urandom_range(0, int'(cfg_max_payload)));
	endfunction

	// Small values hit the status and event codes; the rest is arbitrary.
	function automatic logic [15:0] pick_word();
		if ($urandom_range(0, 99) < 45) return 16'($urandom_range(0, 7));
		return 16'($urandom);
	endfunction

	// Mostly well-formed headers that follow the expected sequence, plus a tenth
	// of pure noise and the odd restart.
	function automatic item_t random_header();
		item_t       h;
		int unsigned pick;
		int unsigned kind;
		int unsigned chan_pick;
		pick = $urandom_range(0, 99);
		h = item_t'({$urandom, $urandom});
		if (pick < 2) begin
			h.restart = 1'b1;
			return h;
		end
		h.restart = 1'b0;
		if (pick < 12) return h;
		h.packet_sequence = ($urandom_range(0, 99) < 92) ? seq_expected : 8'($urandom);
		h.packet_opcode   = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		h.crc_ok          = ($urandom_range(0, 29) != 0);
		h.payload_length  = pick_length();
		h.first_word      = pick_word();
		h.packet_flags    = '0;
		h.packet_flags[0] = 1'($urandom);
		h.packet_flags[FlagAckReq] = ($urandom_range(0, 99) < 40);
		chan_pick = $urandom_range(0, 99);
		h.packet_channel = (chan_pick < 40) ? 8'd0 :
			(chan_pick < 70) ? cfg_stdin_chan : 8'($urandom);
		kind = $urandom_range(0, 99);
		if (kind < 35) h.packet_flags |= F_FRAG;
		else if (kind < 60) h.packet_flags |= '0;
		else if (kind < 72) h.packet_flags |= F_NAK;
		else if (kind < 88) h.packet_flags |= F_EVENT;
		else begin
			h.packet_flags |= F_RTX;
			if ($urandom_range(0, 1) == 1) h.packet_sequence = 8'($urandom);
		end
		return h;
	endfunction

	// Presents one header and holds it until the request is taken. Called at a
	// rising edge; returns at the edge where the header was accepted, so the
	// next call can keep valid high without lowering it in between.
	task automatic send_header(input item_t h);
		int      gap;
		result_t want;
		gap = tx_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= h.restart;
		s_tdata  <= {1'b0, h.first_word, h.crc_ok, h.payload_length, h.packet_opcode,
			h.packet_flags, h.packet_channel, h.packet_sequence};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = predict_response(h);
		expected_q.push_back(want);
		headers_sent++;
		if (want.disposition != DISP_DROPPED) headers_taken++;
		disp_seen[want.disposition]++;
	endtask

	// Stops the header stream and waits until every predicted result has come
	// back, then lets the pipeline settle before any register write.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// Writes one register, then leaves the channel idle before returning.
	task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MAX_PAYLOAD:   cfg_max_payload = value;
			CFG_STDIN_CHANNEL: cfg_stdin_chan  = value[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] max_len, input logic [7:0] stdin_chan);
		drain_results();
		write_register(CFG_MAX_PAYLOAD, max_len);
		write_register(CFG_STDIN_CHANNEL, {8'd0, stdin_chan});
		settings_used++;
	endtask

	// Corner cases under the reset register values (limit 52, stdin channel 0).
	task automatic test_directed_cases();
		item_t h;
		h = '0;
		h.restart = 1'b1;
		send_header(h);
		send_header(make_header(seq_expected, 8'd3, F_ACKREQ, 8'h41, 16'd0, 1'b1, 16'h0));
		// Protocol sync passes with any sequence number.
		send_header(make_header(seq_expected + 8'd9, 8'd4, '0, 8'd0, 16'd2, 1'b1, 16'h1234));
		send_header(make_header(seq_expected, 8'd4, F_ACKREQ, 8'h10, 16'd4, 1'b0, 16'h0));
		send_header(make_header(seq_expected, 8'd4, '0, 8'h10, 16'd53, 1'b1, 16'h0));
		send_header(make_header(seq_expected + 8'd1, 8'd4, F_ACKREQ, 8'h22, 16'd0, 1'b1, 16'h0));
		// Stale retransmit echoes its own sequence; an in-order one is taken normally.
		send_header(make_header(seq_expected + 8'd3, 8'hFF, F_RTX | F_ACKREQ, 8'hFF, 16'd52,
			1'b1, 16'hFFFF));
		send_header(make_header(seq_expected, 8'd2, F_RTX | F_ACK, 8'h33, 16'd1, 1'b1, 16'h0));
		// System channel events: short payload, channel add, unknown code, reboot.
		send_header(make_header(8'd0, 8'd0, F_EVENT, 8'h01, 16'd1, 1'b1, EvtReboot));
		send_header(make_header(8'd0, 8'd0, F_EVENT | F_ACKREQ, 8'h01, 16'd2, 1'b1, EvtChanAdd));
		send_header(make_header(8'd0, 8'd0, F_EVENT, 8'h01, 16'd2, 1'b1, 16'h0009));
		send_header(make_header(8'h77, 8'd0, F_EVENT, 8'h01, 16'd2, 1'b1, EvtReboot));
		// With stdin channel 0 this is still a system event and leaves the script flag.
		send_header(make_header(8'd0, 8'd0, F_EVENT, 8'h01, 16'd2, 1'b1, EvtRunning));
		send_header(make_header(8'd0, 8'd5, F_EVENT | F_ACKREQ, 8'h02, 16'd2, 1'b1, EvtRunning));
		// One byte, an empty fragment, then a fragment whose first byte straddles.
		send_header(make_header(seq_expected, 8'd1, F_FRAG, 8'h05, 16'd1, 1'b1, 16'h00AB));
		send_header(make_header(seq_expected, 8'd1, F_FRAG, 8'h05, 16'd0, 1'b1, 16'h9999));
		send_header(make_header(seq_expected, 8'd1, F_FRAG, 8'h05, 16'd3, 1'b1, 16'h55CD));
		send_header(make_header(seq_expected, 8'd1, F_ACKREQ, 8'h05, 16'd4, 1'b1, 16'h0));
		// Checksum status assembled across two packets.
		send_header(make_header(seq_expected, 8'd1, F_FRAG, 8'h06, 16'd1, 1'b1, 16'h0005));
		send_header(make_header(seq_expected, 8'd1, F_NAK, 8'h06, 16'd1, 1'b1, 16'h0000));
		// Too short to carry a status word.
		send_header(make_header(seq_expected, 8'd1, F_NAK, 8'h06, 16'd1, 1'b1, 16'h0005));
		send_header(make_header(seq_expected, 8'd1, F_NAK, 8'h06, 16'd2, 1'b1, StSequence));
		send_header(make_header(seq_expected, 8'd1, F_NAK, 8'h06, 16'd2, 1'b1, StTimeout));
		send_header(make_header(seq_expected, 8'd1, F_NAK | F_ACKREQ, 8'h06, 16'd2, 1'b1, StBusy));
	endtask

	// Needs the limit at 65535 and stdin channel 7.
	task automatic test_length_saturation();
		send_header(make_header(seq_expected, 8'd9, F_FRAG, 8'h07, LenMax, 1'b1, 16'h0004));
		send_header(make_header(seq_expected, 8'd9, F_FRAG, 8'h07, 16'h0010, 1'b1, 16'h1111));
		send_header(make_header(seq_expected, 8'd9, F_NAK, 8'h07, 16'd5, 1'b1, 16'h2222));
		send_header(make_header(8'd0, cfg_stdin_chan, F_EVENT, 8'h03, 16'd2, 1'b1, EvtRunning));
		send_header(make_header(8'd0, cfg_stdin_chan, F_EVENT, 8'h03, 16'd2, 1'b1, 16'h0000));
	endtask

	task automatic test_random_traffic(input int goal);
		int start;
		start = headers_taken;
		while (headers_taken - start < goal) send_header(random_header());
	endtask

	// Result receiver: random back-pressure with long stalls now and then and
	// stretches where every result is taken at once.
	always @(posedge clk) begin
		if (rx_quiet > 0) begin
			rx_quiet--;
			m_tready <= 1'b1;
		end else if (rx_stall > 0) begin
			rx_stall--;
			m_tready <= 1'b0;
		end else begin
			rx_stall = idle_length();
			if ($urandom_range(0, 99) < 3) rx_quiet = $urandom_range(30, 120);
			m_tready <= (rx_stall == 0);
		end
	end

	function automatic void check_field(input string field, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %0h, got %0h", results_seen, field,
					want_v, got_v);
		end
	endfunction

	// Every accepted result is compared, field by field, with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with no request outstanding", results_seen);
			end else begin
				result_t want;
				want = expected_q.pop_front();
				check_field("disposition", 32'(want.disposition), 32'(m_tuser));
				check_field("send_ack", 32'(want.send_ack), 32'(m_tdata[0]));
				check_field("ack_sequence", 32'(want.ack_sequence), 32'(m_tdata[8:1]));
				check_field("ack_channel", 32'(want.ack_channel), 32'(m_tdata[16:9]));
				check_field("ack_opcode", 32'(want.ack_opcode), 32'(m_tdata[24:17]));
				check_field("error_code", 32'(want.error_code), 32'(m_tdata[27:25]));
				check_field("response_length", 32'(want.response_length),
					32'(m_tdata[43:28]));
				check_field("resync_needed", 32'(want.resync_needed), 32'(m_tdata[44]));
				check_field("channels_changed", 32'(want.channels_changed),
					32'(m_tdata[45]));
				check_field("script_active", 32'(want.script_active), 32'(m_tdata[46]));
				check_field("expected_sequence", 32'(want.expected_sequence),
					32'(m_tdata[54:47]));
			end
		end
	end

	// Watchdog: a hung handshake on any channel ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("no request accepted for %0d cycles", STUCK_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		foreach (disp_seen[i]) disp_seen[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(PHASE_GOAL);

		// Zero-length limit with the top channel carrying script state.
		apply_settings(16'd0, 8'd255);
		test_random_traffic(PHASE_GOAL);

		// Full-range lengths, so fragment sums saturate.
		apply_settings(LenMax, 8'd7);
		test_length_saturation();
		test_random_traffic(PHASE_GOAL);

		apply_settings(16'd1, 8'd0);
		test_random_traffic(PHASE_GOAL);

		apply_settings(16'($urandom_range(2, 400)), 8'($urandom_range(1, 255)));
		test_random_traffic(PHASE_GOAL);

		drain_results();
		repeat (PIPE_DEPTH + 6) @(posedge clk);
		$display("%0d headers sent (%0d not dropped) under %0d register settings, %0d results",
			headers_sent, headers_taken, settings_used, results_seen);
		$display("mix: dropped %0d stale %0d event %0d fragment %0d",
			disp_seen[DISP_DROPPED], disp_seen[DISP_STALE], disp_seen[DISP_EVENT],
			disp_seen[DISP_FRAGMENT]);
		$display("     complete %0d nak %0d restart %0d",
			disp_seen[DISP_COMPLETE], disp_seen[DISP_NAK], disp_seen[DISP_RESTARTED]);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/prs_pkg.sv
hw/rtl/prs_decide.sv
hw/rtl/prs_state.sv
hw/rtl/packet_response_sequencer_top.sv
verif/tb.sv
